@@ rtl/stpc_pkg.sv @@
// ----------------------------------------------------------------------------
// stpc_pkg
// Shared types, widths and constants for the stepper position controller.
// ----------------------------------------------------------------------------
package stpc_pkg;

    localparam int POS_W   = 15;
    localparam int DELAY_W = 16;
    localparam int AMT_W   = 16;
    localparam int OP_W    = 3;
    localparam int COIL_W  = 4;
    localparam int PHASE_W = 2;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 40;

    localparam logic [DELAY_W-1:0] STEP_DELAY_RESET = 16'd10;
    localparam logic [POS_W-1:0]   MAX_POS_RESET    = 15'd1000;
    localparam logic [POS_W-1:0]   MIN_POS_RESET    = 15'd0;

    typedef enum logic [OP_W-1:0] {
        OP_TICK     = 3'd0,
        OP_STOP     = 3'd1,
        OP_MOVE_ABS = 3'd2,
        OP_MOVE_REL = 3'd3,
        OP_HOME     = 3'd4,
        OP_ENABLE   = 3'd5,
        OP_DISABLE  = 3'd6
    } op_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_STEP_DELAY = 2'd0,
        REG_MAX_POS    = 2'd1,
        REG_MIN_POS    = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        STAT_IDLE     = 2'd0,
        STAT_MOVING   = 2'd1,
        STAT_DISABLED = 2'd2,
        STAT_FAULT    = 2'd3
    } status_t;

    localparam logic [COIL_W-1:0] COILS_OFF = 4'h0;
    localparam logic [COIL_W-1:0] COILS_PH0 = 4'hA;
    localparam logic [COIL_W-1:0] COILS_PH1 = 4'h6;
    localparam logic [COIL_W-1:0] COILS_PH2 = 4'h5;
    localparam logic [COIL_W-1:0] COILS_PH3 = 4'h9;

    // Full-step coil pattern for each phase (bit3 A1, bit2 A2, bit1 B1, bit0 B2).
    function automatic logic [COIL_W-1:0] phase_coils(input logic [PHASE_W-1:0] ph);
        logic [COIL_W-1:0] c;
        case (ph)
            2'd0:    c = COILS_PH0;
            2'd1:    c = COILS_PH1;
            2'd2:    c = COILS_PH2;
            default: c = COILS_PH3;
        endcase
        return c;
    endfunction

endpackage

@@ rtl/stepper_position_controller_top.sv @@
// ----------------------------------------------------------------------------
// stepper_position_controller_top
// Two-phase full-step stepper controller with clamped absolute and relative moves,
// home moves, millisecond tick timing, enable, disable and fault handling.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Signals                         Payload
//  s_axis    in         tvalid/tready/tdata/tuser       tuser: op; tdata: amount, fault
//  m_axis    out        tvalid/tready/tdata             coils, driver_awake, position,
//                                                       target, status, forward
//  cfg       in         cfg_we/cfg_addr/cfg_data        step delay, max and min position
//
// Every transaction passes through the input register and then the result register.
// One transaction per cycle is sustained while m_axis does not stall; the position,
// phase and delay registers are updated in a single pass as an item leaves the input
// register. Reset (rst_n low) sets the configuration, controller and valid registers
// to their power-on values, empties both stages and leaves the data registers as
// they are. A stall on m_axis holds the result register and, once the input
// register is also full, drops s_axis_tready until the result is taken.
//
module stepper_position_controller_top
    import stpc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    // Input stream
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [IN_TDATA_W-1:0]   s_axis_tdata,  // [15:0] amount, [16] fault, rest zero
    input  logic [OP_W-1:0]         s_axis_tuser,  // [2:0] op
    // Result stream
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [OUT_TDATA_W-1:0]  m_axis_tdata,  // [3:0] coils, [4] driver_awake,
                                                   // [19:5] position, [34:20] target,
                                                   // [36:35] status, [37] forward,
                                                   // rest zero
    // Configuration writes
    input  logic                    cfg_we,
    input  logic [CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [CFG_DATA_W-1:0]   cfg_data
);

    // Configuration registers.
    logic [DELAY_W-1:0] step_delay_reg;
    logic [POS_W-1:0]   max_pos_reg;
    logic [POS_W-1:0]   min_pos_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_delay_reg <= STEP_DELAY_RESET;
            max_pos_reg    <= MAX_POS_RESET;
            min_pos_reg    <= MIN_POS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_STEP_DELAY: step_delay_reg <= cfg_data;
                REG_MAX_POS:    max_pos_reg    <= cfg_data[POS_W-1:0];
                REG_MIN_POS:    min_pos_reg    <= cfg_data[POS_W-1:0];
                default:        ;
            endcase
        end
    end

    // Input register stage.
    logic                 in_valid_reg;
    logic [OP_W-1:0]      in_op_reg;
    logic [AMT_W-1:0]     in_amount_reg;
    logic                 in_fault_reg;

    // Result register stage.
    logic                   out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic [OUT_TDATA_W-1:0] out_data_next;

    logic advance;
    logic in_accept;

    // The item in the input register moves on whenever the result register is
    // free or is being emptied in this cycle.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_op_reg     <= s_axis_tuser;
            in_amount_reg <= s_axis_tdata[AMT_W-1:0];
            in_fault_reg  <= s_axis_tdata[AMT_W];
        end
    end

    // Controller state.
    logic [POS_W-1:0]   pos_reg,    pos_next;
    logic [POS_W-1:0]   tgt_reg,    tgt_next;
    logic [PHASE_W-1:0] phase_reg,  phase_next;
    logic               moving_reg, moving_next;
    logic               fwd_reg,    fwd_next;
    logic               awake_reg,  awake_next;
    logic [DELAY_W-1:0] delay_reg,  delay_next;
    logic [COIL_W-1:0]  coil_reg,   coil_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            tgt_reg    <= '0;
            phase_reg  <= '0;
            moving_reg <= 1'b0;
            fwd_reg    <= 1'b1;
            awake_reg  <= 1'b1;
            delay_reg  <= '0;
            coil_reg   <= COILS_OFF;
        end
        else if (advance)
        begin
            pos_reg    <= pos_next;
            tgt_reg    <= tgt_next;
            phase_reg  <= phase_next;
            moving_reg <= moving_next;
            fwd_reg    <= fwd_next;
            awake_reg  <= awake_next;
            delay_reg  <= delay_next;
            coil_reg   <= coil_next;
        end
    end

    // Target clamping. A relative move is summed at 17 bits so it never wraps;
    // the upper limit is applied first, then the lower, so the lower limit wins
    // when the two limits cross.
    logic signed [AMT_W:0] amount_ext;
    logic signed [AMT_W:0] rel_sum;
    logic signed [AMT_W:0] raw_target;
    logic signed [AMT_W:0] max_ext;
    logic signed [AMT_W:0] min_ext;
    logic signed [AMT_W:0] clamp_hi;
    logic signed [AMT_W:0] clamp_lo;
    logic [POS_W-1:0]      clamped_target;

    assign amount_ext = $signed({in_amount_reg[AMT_W-1], in_amount_reg});
    assign rel_sum    = $signed({2'b00, pos_reg}) + amount_ext;
    assign raw_target = (in_op_reg == OP_MOVE_REL) ? rel_sum : amount_ext;
    assign max_ext    = $signed({2'b00, max_pos_reg});
    assign min_ext    = $signed({2'b00, min_pos_reg});
    assign clamp_hi   = (raw_target > max_ext) ? max_ext : raw_target;
    assign clamp_lo   = (clamp_hi < min_ext) ? min_ext : clamp_hi;
    assign clamped_target = clamp_lo[POS_W-1:0];

    // Command decode, then the fault rule, then tick timing and stepping.
    logic [POS_W-1:0]   cmd_tgt;
    logic               cmd_moving;
    logic               cmd_awake;
    logic [COIL_W-1:0]  cmd_coil;
    logic               do_move;
    logic [POS_W-1:0]   move_tgt;
    logic [PHASE_W-1:0] step_phase;
    logic [POS_W-1:0]   step_pos;
    status_t            status;

    always_comb
    begin
        cmd_tgt    = tgt_reg;
        cmd_moving = moving_reg;
        cmd_awake  = awake_reg;
        cmd_coil   = coil_reg;
        do_move    = 1'b0;
        move_tgt   = clamped_target;

        case (in_op_reg)
            OP_STOP:
            begin
                cmd_moving = 1'b0;
                cmd_coil   = COILS_OFF;
            end
            OP_MOVE_ABS, OP_MOVE_REL:
            begin
                do_move = 1'b1;
            end
            OP_HOME:
            begin
                do_move  = 1'b1;
                move_tgt = '0;
            end
            OP_ENABLE:
            begin
                cmd_awake = 1'b1;
            end
            OP_DISABLE:
            begin
                cmd_awake  = 1'b0;
                cmd_moving = 1'b0;
                cmd_coil   = COILS_OFF;
            end
            default: ;
        endcase

        // A move to the current position finishes at once with the coils off.
        if (do_move)
        begin
            cmd_tgt = move_tgt;
            if (move_tgt == pos_reg)
            begin
                cmd_moving = 1'b0;
                cmd_coil   = COILS_OFF;
            end
            else
            begin
                cmd_moving = 1'b1;
            end
        end

        pos_next    = pos_reg;
        tgt_next    = cmd_tgt;
        phase_next  = phase_reg;
        moving_next = cmd_moving;
        fwd_next    = fwd_reg;
        awake_next  = cmd_awake;
        delay_next  = delay_reg;
        coil_next   = cmd_coil;

        if (pos_reg < cmd_tgt)
        begin
            step_phase = phase_reg + 2'd1;
            step_pos   = pos_reg + 15'd1;
        end
        else
        begin
            step_phase = phase_reg - 2'd1;
            step_pos   = pos_reg - 15'd1;
        end

        if (in_fault_reg)
        begin
            moving_next = 1'b0;
            coil_next   = COILS_OFF;
        end
        else if (in_op_reg == OP_TICK)
        begin
            if (delay_reg != '0)
            begin
                delay_next = delay_reg - 16'd1;
            end
            else if (cmd_moving && (pos_reg != cmd_tgt))
            begin
                fwd_next   = (pos_reg < cmd_tgt);
                phase_next = step_phase;
                pos_next   = step_pos;
                delay_next = step_delay_reg;
                if (step_pos == cmd_tgt)
                begin
                    moving_next = 1'b0;
                    coil_next   = COILS_OFF;
                end
                else
                begin
                    coil_next = phase_coils(step_phase);
                end
            end
            else if (!cmd_moving)
            begin
                coil_next = COILS_OFF;
            end
        end

        if (in_fault_reg)
            status = STAT_FAULT;
        else if (!awake_next)
            status = STAT_DISABLED;
        else if (moving_next)
            status = STAT_MOVING;
        else
            status = STAT_IDLE;

        out_data_next = {2'b00, fwd_next, status, tgt_next, pos_next, awake_next, coil_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

@@ rtl/stpc_checker.sv @@
// ----------------------------------------------------------------------------
// stpc_checker
// Port-level checks for the stepper position controller, bound to the top.
// ----------------------------------------------------------------------------
module stpc_checker
    import stpc_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    s_axis_tvalid,
    input logic                    s_axis_tready,
    input logic                    m_axis_tvalid,
    input logic                    m_axis_tready,
    input logic [OUT_TDATA_W-1:0]  m_axis_tdata
);

    logic [COIL_W-1:0] coils;
    logic              awake;
    logic [1:0]        status;

    assign coils  = m_axis_tdata[3:0];
    assign awake  = m_axis_tdata[4];
    assign status = m_axis_tdata[36:35];

    // A stalled result transaction holds its data.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // A result only follows an earlier input transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
        else $error("result without a preceding input transaction");

    // Coils are off or show one of the four full-step patterns.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (coils == COILS_OFF) || (coils == COILS_PH0) ||
                          (coils == COILS_PH1) || (coils == COILS_PH2) ||
                          (coils == COILS_PH3))
        else $error("illegal coil pattern");

    // A fault always leaves the coils de-energized.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (status == STAT_FAULT) |-> coils == COILS_OFF)
        else $error("coils driven during fault");

    // Disabled status and the sleep level agree.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (status != STAT_FAULT) |-> ((status == STAT_DISABLED) == !awake))
        else $error("status disagrees with driver sleep level");

endmodule

bind stepper_position_controller_top stpc_checker u_stpc_checker (.*);
